[sv/mid_pkg.sv]
// shared types, register map and reset values for the motion idle/sleep detector
package mid_pkg;

  // register map, index is paddr[4:2]
  localparam int unsigned PADDR_W = 5;
  localparam logic [2:0] REG_IDLE_THR     = 3'd0;
  localparam logic [2:0] REG_SLEEP_THR    = 3'd1;
  localparam logic [2:0] REG_WAKE_COUNT   = 3'd2;
  localparam logic [2:0] REG_DECAY_INTVL  = 3'd3;
  localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd4;

  // register reset values
  localparam logic [15:0] IDLE_THR_RST     = 16'd26;
  localparam logic [15:0] SLEEP_THR_RST    = 16'd51;
  localparam logic [7:0]  WAKE_COUNT_RST   = 8'd3;
  localparam logic [7:0]  DECAY_INTVL_RST  = 8'd10;
  localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd60000;

  // saturation limit of the motion counter
  localparam logic [7:0] MOTION_CNT_MAX = 8'd255;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] accel_magnitude;
    logic        gate_open;
  } mid_in_t;

  typedef struct packed {
    logic motion_seen;
    logic entered_sleep;
    logic woke_up;
    logic asleep;
  } mid_out_t;

endpackage

[sv/mid_in_if.sv]
// valid/ready channel carrying one sensor sample
interface mid_in_if;
  import mid_pkg::*;

  logic    valid;
  logic    ready;
  mid_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/mid_out_if.sv]
// valid/ready channel carrying one detector result
interface mid_out_if;
  import mid_pkg::*;

  logic     valid;
  logic     ready;
  mid_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/motion_idle_sleep_detector_unit.sv]
// top level of the accelerometer idle/sleep detector with apb register port
//
//   channel  dir  handshake       payload
//   in_i     in   valid/ready     now_ms[31:0], accel_magnitude[15:0], gate_open
//   out_o    out  valid/ready     motion_seen, entered_sleep, woke_up, asleep
//   apb      in   psel/penable    paddr[4:0], pwdata[31:0] -> prdata[31:0], pready
//
// an input transaction reaches the result through the sample register, then compare and
// state update into the result register.
// one sample per cycle is taken as long as the result side keeps draining.
// a stalled result holds the result register; the sample register takes one more
// sample, then in_i.ready stays low until the result drains.
// rst_ni clears the detector state and loads the register reset values at once.
module motion_idle_sleep_detector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mid_in_if.sink                        in_i,
  mid_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mid_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mid_pkg::*;

  // configuration registers
  logic [15:0] idle_thr_q;
  logic [15:0] sleep_thr_q;
  logic [7:0]  wake_count_q;
  logic [7:0]  decay_intvl_q;
  logic [31:0] idle_timeout_q;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // pipeline control
  logic        smp_valid_q;
  mid_in_t     smp_q;
  logic        res_valid_q;
  mid_out_t    res_q;
  logic        res_adv;
  logic        smp_adv;

  // detector state
  logic        base_valid_q, base_valid_d;
  logic [15:0] base_level_q, base_level_d;
  logic [31:0] still_start_q, still_start_d;
  logic [7:0]  motion_cnt_q, motion_cnt_d;
  logic [7:0]  decay_tick_q, decay_tick_d;
  logic        sleep_q, sleep_d;
  mid_out_t    res_d;

  // datapath helpers
  logic [15:0] delta;
  logic [15:0] thr;
  logic        motion;
  logic [7:0]  cnt_inc;
  logic [7:0]  tick_inc;
  logic [31:0] still_elapsed;

  // apb access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_thr_q     <= IDLE_THR_RST;
      sleep_thr_q    <= SLEEP_THR_RST;
      wake_count_q   <= WAKE_COUNT_RST;
      decay_intvl_q  <= DECAY_INTVL_RST;
      idle_timeout_q <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IDLE_THR:     idle_thr_q     <= pwdata[15:0];
        REG_SLEEP_THR:    sleep_thr_q    <= pwdata[15:0];
        REG_WAKE_COUNT:   wake_count_q   <= pwdata[7:0];
        REG_DECAY_INTVL:  decay_intvl_q  <= pwdata[7:0];
        REG_IDLE_TIMEOUT: idle_timeout_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_IDLE_THR:     prdata = {16'd0, idle_thr_q};
      REG_SLEEP_THR:    prdata = {16'd0, sleep_thr_q};
      REG_WAKE_COUNT:   prdata = {24'd0, wake_count_q};
      REG_DECAY_INTVL:  prdata = {24'd0, decay_intvl_q};
      REG_IDLE_TIMEOUT: prdata = idle_timeout_q;
      default:          prdata = 32'd0;
    endcase
  end

  // flow control: result register drains, sample register refills
  assign res_adv     = !res_valid_q || out_o.ready;
  assign smp_adv     = smp_valid_q && res_adv;
  assign in_i.ready  = !smp_valid_q || res_adv;
  assign out_o.valid = res_valid_q;
  assign out_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        smp_valid_q <= in_i.valid;
      end
      if (res_adv) begin
        res_valid_q <= smp_valid_q;
      end
    end
  end

  // sample register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      smp_q <= in_i.payload;
    end
  end

  // difference from baseline against the active threshold
  assign delta    = (smp_q.accel_magnitude >= base_level_q)
                  ? (smp_q.accel_magnitude - base_level_q)
                  : (base_level_q - smp_q.accel_magnitude);
  assign thr      = sleep_q ? sleep_thr_q : idle_thr_q;
  assign motion   = delta > thr;
  assign cnt_inc  = (motion_cnt_q == MOTION_CNT_MAX) ? motion_cnt_q : motion_cnt_q + 8'd1;
  assign tick_inc = decay_tick_q + 8'd1;
  assign still_elapsed = smp_q.now_ms - still_start_q;

  // next state and result for the sample in the sample register
  always_comb begin
    base_valid_d  = base_valid_q;
    base_level_d  = base_level_q;
    still_start_d = still_start_q;
    motion_cnt_d  = motion_cnt_q;
    decay_tick_d  = decay_tick_q;
    sleep_d       = sleep_q;
    res_d         = '0;

    if (smp_q.gate_open) begin
      if (!base_valid_q) begin
        // first gated sample latches the baseline
        base_valid_d  = 1'b1;
        base_level_d  = smp_q.accel_magnitude;
        still_start_d = smp_q.now_ms;
      end else if (motion) begin
        res_d.motion_seen = 1'b1;
        motion_cnt_d      = cnt_inc;
        if (sleep_q) begin
          if (cnt_inc >= wake_count_q) begin
            still_start_d = 32'd0;
            motion_cnt_d  = 8'd0;
            sleep_d       = 1'b0;
            res_d.woke_up = 1'b1;
          end
        end else begin
          still_start_d = smp_q.now_ms;
        end
      end else begin
        // quiet sample
        if (sleep_q) begin
          decay_tick_d = tick_inc;
          if (tick_inc >= decay_intvl_q && motion_cnt_q != 8'd0) begin
            motion_cnt_d = motion_cnt_q - 8'd1;
            decay_tick_d = 8'd0;
          end
        end else begin
          motion_cnt_d = 8'd0;
        end
        if (still_start_q == 32'd0) begin
          still_start_d = smp_q.now_ms;
        end else if (!sleep_q && still_elapsed >= idle_timeout_q) begin
          sleep_d             = 1'b1;
          res_d.entered_sleep = 1'b1;
        end
      end
    end
    res_d.asleep = sleep_d;
  end

  // state update, one sample per advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_valid_q  <= 1'b0;
      base_level_q  <= 16'd0;
      still_start_q <= 32'd0;
      motion_cnt_q  <= 8'd0;
      decay_tick_q  <= 8'd0;
      sleep_q       <= 1'b0;
    end else if (smp_adv) begin
      base_valid_q  <= base_valid_d;
      base_level_q  <= base_level_d;
      still_start_q <= still_start_d;
      motion_cnt_q  <= motion_cnt_d;
      decay_tick_q  <= decay_tick_d;
      sleep_q       <= sleep_d;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (smp_adv) begin
      res_q <= res_d;
    end
  end

endmodule

[sv/mid_checker.sv]
// port level checks for the motion idle/sleep detector, bound to the top level
module mid_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input mid_pkg::mid_out_t out_payload_i,
  input logic              pready_i
);
  import mid_pkg::*;

  // a result never both enters and leaves sleep
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_payload_i.entered_sleep && out_payload_i.woke_up))
    else $error("entered_sleep and woke_up both set");

  // wake only comes from a motion sample and leaves the block awake
  a_wake_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_payload_i.woke_up) |->
      (out_payload_i.motion_seen && !out_payload_i.asleep))
    else $error("woke_up without motion or still asleep");

  // entering sleep comes from a quiet sample and leaves the block asleep
  a_sleep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_payload_i.entered_sleep) |->
      (!out_payload_i.motion_seen && out_payload_i.asleep))
    else $error("entered_sleep with motion or not asleep");

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)))
    else $error("stalled result changed");

  // the register port never inserts wait states
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind motion_idle_sleep_detector_unit mid_checker u_mid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload),
  .pready_i      (pready)
);

[tb/sv/tb_motion_idle_sleep_detector_unit.sv]
// self-checking testbench for the motion idle/sleep detector top level
module tb_motion_idle_sleep_detector_unit;
  import mid_pkg::*;

  // baseline latched by the first gated sample of the run
  localparam int BASELINE = 1000;
  localparam int N_DIRECTED = 26;
  localparam int N_PHASES = 9;
  localparam int N_FIXED_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 103;
  localparam int SEG_LEN = 16;
  localparam int WDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES = 8;

  // result flag patterns {motion_seen, entered_sleep, woke_up, asleep}
  localparam mid_out_t FLAGS_NONE         = 4'b0000;
  localparam mid_out_t FLAGS_MOTION       = 4'b1000;
  localparam mid_out_t FLAGS_SLEPT        = 4'b0101;
  localparam mid_out_t FLAGS_ASLEEP       = 4'b0001;
  localparam mid_out_t FLAGS_MOTION_ASLP  = 4'b1001;
  localparam mid_out_t FLAGS_WOKE         = 4'b1010;

  typedef struct packed {
    logic [15:0] idle_thr;
    logic [15:0] sleep_thr;
    logic [7:0]  wake_cnt;
    logic [7:0]  decay_intvl;
    logic [31:0] idle_timeout;
  } det_cfg_t;

  typedef struct {
    logic [31:0] now;
    logic [15:0] mag;
    logic        gate;
    bit          typed;
    mid_out_t    flags;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  mid_in_if  smp_if ();
  mid_out_if res_if ();

  motion_idle_sleep_detector_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (smp_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // typed-in expectation travels with the sample payload
  logic     pin_typed;
  mid_out_t pin_flags;

  // predictor configuration and state
  det_cfg_t    cfg = '{IDLE_THR_RST, SLEEP_THR_RST, WAKE_COUNT_RST, DECAY_INTVL_RST,
                       IDLE_TIMEOUT_RST};
  logic        bl_valid = 1'b0;
  logic [15:0] bl_level = '0;
  logic [31:0] still_ts = '0;
  logic [7:0]  motion_cnt = '0;
  logic [7:0]  decay_cnt = '0;
  logic        sleeping = 1'b0;

  mid_out_t    pending_flags [$];
  mid_out_t    sample_flags;
  mid_out_t    got_flags;
  int          err_cnt = 0;
  int          idle_cycles = 0;
  bit          burst = 1'b0;
  int          motion_pct = 50;
  logic [31:0] tstamp = '0;

  // directed samples: threshold edges, timeout, wrap, wake and decay
  dir_row_t dir_rows [0:N_DIRECTED-1] = '{
    '{32'hFFFF_FFFF, 16'hFFFF,             1'b0, 1'b1, FLAGS_NONE},
    '{32'd0,         16'(BASELINE),        1'b1, 1'b1, FLAGS_NONE},
    '{32'd100,       16'(BASELINE + 27),   1'b1, 1'b1, FLAGS_MOTION},
    '{32'd200,       16'(BASELINE + 26),   1'b1, 1'b1, FLAGS_NONE},
    '{32'd300,       16'(BASELINE - 27),   1'b1, 1'b1, FLAGS_MOTION},
    '{32'd60300,     16'(BASELINE),        1'b1, 1'b1, FLAGS_SLEPT},
    '{32'd60400,     16'h0000,             1'b0, 1'b1, FLAGS_ASLEEP},
    '{32'd60500,     16'(BASELINE + 51),   1'b1, 1'b1, FLAGS_ASLEEP},
    '{32'd60600,     16'(BASELINE + 52),   1'b1, 1'b1, FLAGS_MOTION_ASLP},
    '{32'd60700,     16'h0000,             1'b1, 1'b1, FLAGS_MOTION_ASLP},
    '{32'd60800,     16'hFFFF,             1'b1, 1'b1, FLAGS_WOKE},
    '{32'd5,         16'(BASELINE),        1'b1, 1'b1, FLAGS_NONE},
    '{32'd4,         16'(BASELINE),        1'b1, 1'b1, FLAGS_SLEPT},
    '{32'd10,        16'(BASELINE - 52),   1'b1, 1'b0, FLAGS_NONE},
    '{32'd20,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd30,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd40,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd50,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd60,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd70,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd80,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd90,        16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd100,       16'(BASELINE),        1'b1, 1'b0, FLAGS_NONE},
    '{32'd110,       16'(BASELINE - 52),   1'b1, 1'b0, FLAGS_NONE},
    '{32'd120,       16'(BASELINE + 52),   1'b1, 1'b0, FLAGS_NONE},
    '{32'd130,       16'(BASELINE - 52),   1'b1, 1'b0, FLAGS_NONE}
  };

  // register settings per random phase, the last ones are drawn at run time
  det_cfg_t phase_cfgs [0:N_FIXED_PHASES-1] = '{
    '{IDLE_THR_RST, SLEEP_THR_RST, WAKE_COUNT_RST, DECAY_INTVL_RST, IDLE_TIMEOUT_RST},
    '{16'd0,     16'd0,     8'd1,   8'd1,   32'd0},
    '{16'hFFFF,  16'hFFFF,  8'd255, 8'd255, 32'hFFFF_FFFF},
    '{16'd100,   16'd300,   8'd2,   8'd4,   32'd5000},
    '{16'd300,   16'd100,   8'd5,   8'd3,   32'd2000},
    '{16'd40,    16'd0,     8'd0,   8'd0,   32'd100},
    '{16'd0,     16'd0,     8'd255, 8'd255, 32'd50}
  };

  // clock, period 4
  always begin
    #2 clk_i = 1'b0;
    #2 clk_i = 1'b1;
  end

  // detector predictor, one call per accepted sample
  function automatic mid_out_t predict_detector(input mid_in_t s);
    logic [15:0] delta;
    logic [15:0] thr;
    logic [31:0] elapsed;
    mid_out_t    r;
    r = FLAGS_NONE;
    if (s.gate_open) begin
      if (!bl_valid) begin
        bl_level = s.accel_magnitude;
        bl_valid = 1'b1;
        still_ts = s.now_ms;
      end else begin
        delta = (s.accel_magnitude >= bl_level) ? s.accel_magnitude - bl_level
                                                : bl_level - s.accel_magnitude;
        thr = sleeping ? cfg.sleep_thr : cfg.idle_thr;
        r.motion_seen = (delta > thr);
        if (r.motion_seen) begin
          if (motion_cnt != MOTION_CNT_MAX) motion_cnt = motion_cnt + 8'd1;
          if (sleeping) begin
            // sustained motion wakes
            if (motion_cnt >= cfg.wake_cnt) begin
              still_ts = '0;
              motion_cnt = '0;
              sleeping = 1'b0;
              r.woke_up = 1'b1;
            end
          end else begin
            still_ts = s.now_ms;
          end
        end else begin
          if (sleeping) begin
            // quiet while asleep decays the motion count
            decay_cnt = decay_cnt + 8'd1;
            if (decay_cnt >= cfg.decay_intvl && motion_cnt != 8'd0) begin
              motion_cnt = motion_cnt - 8'd1;
              decay_cnt = '0;
            end
          end else begin
            motion_cnt = '0;
          end
          elapsed = s.now_ms - still_ts;
          if (still_ts == 32'd0) begin
            still_ts = s.now_ms;
          end else if (!sleeping && elapsed >= cfg.idle_timeout) begin
            sleeping = 1'b1;
            r.entered_sleep = 1'b1;
          end
        end
      end
    end
    r.asleep = sleeping;
    return r;
  endfunction

  // random sample around the baseline, biased by the active thresholds
  function automatic mid_in_t make_sample();
    mid_in_t     s;
    int          delta;
    int          lo;
    int          hi;
    int unsigned k;
    logic [31:0] step_max;
    lo = (cfg.idle_thr < cfg.sleep_thr) ? int'(cfg.idle_thr) : int'(cfg.sleep_thr);
    hi = (cfg.idle_thr > cfg.sleep_thr) ? int'(cfg.idle_thr) : int'(cfg.sleep_thr);
    step_max = (cfg.idle_timeout >> 1) + 32'd8;
    // timestamps mostly advance, with jumps and zero stamps mixed in
    k = $urandom_range(0, 31);
    if (k == 0) begin
      s.now_ms = '0;
    end else begin
      if (k == 1) tstamp = $urandom();
      else tstamp = tstamp + $urandom_range(0, step_max);
      s.now_ms = tstamp;
    end
    k = $urandom_range(0, 15);
    if (k == 0) begin
      s.accel_magnitude = 16'($urandom_range(0, 65535));
    end else begin
      if (k == 1) begin
        delta = int'(($urandom_range(0, 1) ? int'(cfg.idle_thr) : int'(cfg.sleep_thr))
                + $urandom_range(0, 1));
      end else if ($urandom_range(0, 99) < motion_pct) begin
        delta = int'(hi + 1 + $urandom_range(0, 3));
      end else begin
        delta = int'($urandom_range(0, lo));
      end
      if (delta > 65535) delta = 65535;
      if (BASELINE + delta <= 65535 && ($urandom_range(0, 1) || delta > BASELINE))
        s.accel_magnitude = 16'(BASELINE + delta);
      else if (delta <= BASELINE)
        s.accel_magnitude = 16'(BASELINE - delta);
      else
        s.accel_magnitude = 16'hFFFF;
    end
    s.gate_open = ($urandom_range(0, 7) != 0);
    return s;
  endfunction

  function automatic void check_bit(input string name, input logic e, input logic a);
    if (e !== a) begin
      $error("%s mismatch: expected %0b, got %0b", name, e, a);
      err_cnt++;
    end
  endfunction

  // one sample transaction, after a random gap outside bursts
  task automatic send_sample(input mid_in_t s, input bit typed, input mid_out_t flags);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid   <= 1'b1;
    smp_if.payload <= s;
    pin_typed      <= typed;
    pin_flags      <= flags;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    smp_if.valid <= 1'b0;
    // wait for the clock so the last accepted sample is queued before the check
    @(posedge clk_i);
    while (pending_flags.size() != 0) @(posedge clk_i);
  endtask

  // apb write, setup then access; psel is left high for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_IDLE_THR:     cfg.idle_thr = val[15:0];
      REG_SLEEP_THR:    cfg.sleep_thr = val[15:0];
      REG_WAKE_COUNT:   cfg.wake_cnt = val[7:0];
      REG_DECAY_INTVL:  cfg.decay_intvl = val[7:0];
      REG_IDLE_TIMEOUT: cfg.idle_timeout = val;
      default: ;
    endcase
  endtask

  task automatic write_cfg(input det_cfg_t c);
    write_reg(REG_IDLE_THR, {16'd0, c.idle_thr});
    write_reg(REG_SLEEP_THR, {16'd0, c.sleep_thr});
    write_reg(REG_WAKE_COUNT, {24'd0, c.wake_cnt});
    write_reg(REG_DECAY_INTVL, {24'd0, c.decay_intvl});
    write_reg(REG_IDLE_TIMEOUT, c.idle_timeout);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // main stimulus
  initial begin
    det_cfg_t c;
    mid_in_t  s;
    rst_ni         <= 1'b0;
    smp_if.valid   <= 1'b0;
    smp_if.payload <= '0;
    pin_typed      <= 1'b0;
    pin_flags      <= FLAGS_NONE;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    for (int i = 0; i < N_DIRECTED; i++) begin
      s.now_ms = dir_rows[i].now;
      s.accel_magnitude = dir_rows[i].mag;
      s.gate_open = dir_rows[i].gate;
      send_sample(s, dir_rows[i].typed, dir_rows[i].flags);
    end

    // random phases, each with its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p < N_FIXED_PHASES) begin
        c = phase_cfgs[p];
      end else begin
        c.idle_thr = 16'($urandom_range(0, 600));
        c.sleep_thr = 16'($urandom_range(0, 600));
        c.wake_cnt = 8'($urandom_range(1, 8));
        c.decay_intvl = 8'($urandom_range(1, 12));
        c.idle_timeout = $urandom_range(0, 100000);
      end
      write_cfg(c);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % SEG_LEN == 0) begin
          burst = ($urandom_range(0, 3) == 0);
          case ($urandom_range(0, 2))
            0: motion_pct = 5;
            1: motion_pct = 50;
            default: motion_pct = 95;
          endcase
        end
        send_sample(make_sample(), 1'b0, FLAGS_NONE);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side ready with random stalls
  initial begin
    int unsigned gap;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // predict on each accepted sample transaction
  always @(posedge clk_i) begin
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      sample_flags = predict_detector(smp_if.payload);
      if (pin_typed) pending_flags.push_back(pin_flags);
      else pending_flags.push_back(sample_flags);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_flags.size() == 0) begin
        $error("result with nothing expected: %b", res_if.payload);
        err_cnt++;
      end else begin
        got_flags = pending_flags.pop_front();
        check_bit("motion_seen", got_flags.motion_seen, res_if.payload.motion_seen);
        check_bit("entered_sleep", got_flags.entered_sleep, res_if.payload.entered_sleep);
        check_bit("woke_up", got_flags.woke_up, res_if.payload.woke_up);
        check_bit("asleep", got_flags.asleep, res_if.payload.asleep);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
